// ----- rtl/tps_pkg.sv -----
// ----------------------------------------------------------------------------
// tps_pkg: shared types and constants
// Coordinate formats, transaction structs and queue entry for the plane split.
// ----------------------------------------------------------------------------
package tps_pkg;

	localparam int COORD_BITS  = 16;
	localparam int FRAC_BITS   = 14;
	localparam int OFFSET_BITS = 14;
	localparam int QUEUE_DEPTH = 2;

	// default offset is one half
	localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = OFFSET_BITS'(1) << (FRAC_BITS - 1);

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t ax;
		coord_t ay;
		coord_t az;
		coord_t bx;
		coord_t by_coord;
		coord_t bz;
		coord_t cx;
		coord_t cy;
		coord_t cz;
	} in_t;

	typedef struct packed {
		logic   side;
		coord_t p0x;
		coord_t p0y;
		coord_t p0z;
		coord_t p1x;
		coord_t p1y;
		coord_t p1z;
		coord_t p2x;
		coord_t p2y;
		coord_t p2z;
		logic   last_tri;
	} out_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vtx_t;

	// triangle classes; the straddling ones name the edge pair that is cut
	typedef enum logic [2:0] {
		KIND_LEFT,
		KIND_RIGHT,
		KIND_PQ,
		KIND_QS,
		KIND_PS
	} kind_t;

	typedef struct packed {
		vtx_t  a;
		vtx_t  b;
		vtx_t  c;
		kind_t kind;
		logic  flip;
	} entry_t;

endpackage

// ----- rtl/tps_front.sv -----
// ----------------------------------------------------------------------------
// tps_front: input stage and classifier
// Accepts triangles, sorts them into left, right or one of the cut cases.
// ----------------------------------------------------------------------------
module tps_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  tps_pkg::in_t   in_data,
	output logic           push,
	output tps_pkg::entry_t push_data,
	input  logic           full
);

	localparam int CB = tps_pkg::COORD_BITS;

	tps_pkg::entry_t ent;
	tps_pkg::entry_t ent_s1;
	logic            valid_s1;
	logic            le_a, le_b, le_c, ge_a, ge_b, ge_c;
	logic            cut_p, cut_q, cut_s;

	// sign tests, zero counts for either side
	always_comb begin
		le_a = in_data.ax[CB-1] || (in_data.ax == '0);
		le_b = in_data.bx[CB-1] || (in_data.bx == '0);
		le_c = in_data.cx[CB-1] || (in_data.cx == '0);
		ge_a = !in_data.ax[CB-1];
		ge_b = !in_data.bx[CB-1];
		ge_c = !in_data.cx[CB-1];
		cut_p = (in_data.ax != in_data.bx) && ((le_a && ge_b) || (ge_a && le_b));
		cut_q = (in_data.bx != in_data.cx) && ((le_b && ge_c) || (ge_b && le_c));
		cut_s = (in_data.cx != in_data.ax) && ((le_c && ge_a) || (ge_c && le_a));
	end

	// classification
	always_comb begin
		ent.a    = '{x: in_data.ax, y: in_data.ay, z: in_data.az};
		ent.b    = '{x: in_data.bx, y: in_data.by_coord, z: in_data.bz};
		ent.c    = '{x: in_data.cx, y: in_data.cy, z: in_data.cz};
		ent.flip = !le_a;
		if (le_a && le_b && le_c) begin
			ent.kind = tps_pkg::KIND_LEFT;
		end else if (ge_a && ge_b && ge_c) begin
			ent.kind = tps_pkg::KIND_RIGHT;
		end else if (cut_p && cut_q) begin
			ent.kind = tps_pkg::KIND_PQ;
		end else if (cut_q && cut_s) begin
			ent.kind = tps_pkg::KIND_QS;
		end else begin
			ent.kind = tps_pkg::KIND_PS;
			ent.flip = !le_b;
		end
	end

	assign in_stall  = valid_s1 && full;
	assign push      = valid_s1 && !full;
	assign push_data = ent_s1;

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			ent_s1 <= ent;
		end
	end

endmodule

// ----- rtl/tps_fifo.sv -----
// ----------------------------------------------------------------------------
// tps_fifo: queue between classifier and split engine
// Small register queue of classified triangles.
// ----------------------------------------------------------------------------
module tps_fifo #(
	parameter int DEPTH = tps_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tps_pkg::entry_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output tps_pkg::entry_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tps_pkg::entry_t      mem_q [DEPTH];
	logic [PW-1:0]        wr_q;
	logic [PW-1:0]        rd_q;
	logic [CW-1:0]        cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// ----- rtl/tps_div.sv -----
// ----------------------------------------------------------------------------
// tps_div: bit-serial signed divider
// Restoring division on magnitudes, one quotient bit per cycle, QW quotient bits.
// ----------------------------------------------------------------------------
module tps_div #(
	parameter int NW = 32,
	parameter int DW = 17,
	parameter int QW = 17
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NW-1:0]       num,
	input  logic [DW-1:0]       den,
	input  logic                neg,
	output logic                done,
	output logic signed [QW:0]  quo
);

	localparam int KW = $clog2(QW + 1);

	logic [DW-1:0] rem_q;
	logic [QW-1:0] lo_q;
	logic [DW-1:0] den_q;
	logic          neg_q;
	logic [KW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          ge;

	// one restoring step
	always_comb begin
		trial = {rem_q, lo_q[QW-1]};
		ge    = (trial >= {1'b0, den_q});
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed({1'b0, lo_q}) : $signed({1'b0, lo_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == KW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// the high numerator part is already below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DW'(num[NW-1:QW]);
			lo_q  <= num[QW-1:0];
			den_q <= den;
			neg_q <= neg;
		end else if (busy_q) begin
			rem_q <= ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			lo_q  <= {lo_q[QW-2:0], ge};
		end
	end

endmodule

// ----- rtl/tps_back.sv -----
// ----------------------------------------------------------------------------
// tps_back: split engine
// Computes edge crossings, emits split triangles one per cycle unless stalled.
// ----------------------------------------------------------------------------
module tps_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              empty,
	input  tps_pkg::entry_t                   head,
	output logic                              pop,
	input  logic [tps_pkg::OFFSET_BITS-1:0]   offset,
	output logic                              out_valid,
	input  logic                              out_stall,
	output tps_pkg::out_t                     out_data
);

	localparam int CB = tps_pkg::COORD_BITS;
	localparam int OB = tps_pkg::OFFSET_BITS;
	localparam int NW = 2 * CB;
	localparam int DW = CB + 1;
	localparam int QW = CB + 1;
	localparam int SW = ((CB > OB) ? CB : OB) + 2;

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_EMIT} state_t;
	typedef enum logic [2:0] {SEL_A, SEL_B, SEL_C, SEL_X1, SEL_X2} sel_t;

	state_t          state_q;
	tps_pkg::entry_t ent_q;
	logic [1:0]      idx_q;
	logic [1:0]      cnt_q;
	logic            out_valid_q;
	tps_pkg::out_t   out_q;

	tps_pkg::vtx_t   e1x, e1y, e2x, e2y;
	tps_pkg::vtx_t   v1, v2;
	logic [NW-1:0]   num [4];
	logic [DW-1:0]   den [4];
	logic            neg [4];
	logic            done [4];
	logic signed [QW:0] quo [4];
	sel_t            sel0, sel1, sel2;
	logic            side;
	logic            load;
	tps_pkg::vtx_t   w0, w1, w2;

	// edges that carry the two crossings
	always_comb begin
		case (ent_q.kind)
			tps_pkg::KIND_QS: begin
				e1x = ent_q.c; e1y = ent_q.a; e2x = ent_q.b; e2y = ent_q.c;
			end
			tps_pkg::KIND_PS: begin
				e1x = ent_q.a; e1y = ent_q.b; e2x = ent_q.c; e2y = ent_q.a;
			end
			default: begin
				e1x = ent_q.a; e1y = ent_q.b; e2x = ent_q.b; e2y = ent_q.c;
			end
		endcase
	end

	// numerators X.x*(Y-X) and denominators X.x-Y.x as magnitudes
	always_comb begin
		logic signed [CB:0]   dlt [4];
		logic signed [CB:0]   dd  [2];
		logic signed [NW:0]   prd [4];
		dlt[0] = $signed({e1y.y[CB-1], e1y.y}) - $signed({e1x.y[CB-1], e1x.y});
		dlt[1] = $signed({e1y.z[CB-1], e1y.z}) - $signed({e1x.z[CB-1], e1x.z});
		dlt[2] = $signed({e2y.y[CB-1], e2y.y}) - $signed({e2x.y[CB-1], e2x.y});
		dlt[3] = $signed({e2y.z[CB-1], e2y.z}) - $signed({e2x.z[CB-1], e2x.z});
		dd[0]  = $signed({e1x.x[CB-1], e1x.x}) - $signed({e1y.x[CB-1], e1y.x});
		dd[1]  = $signed({e2x.x[CB-1], e2x.x}) - $signed({e2y.x[CB-1], e2y.x});
		for (int i = 0; i < 4; i++) begin
			prd[i] = (i < 2) ? $signed(e1x.x) * dlt[i] : $signed(e2x.x) * dlt[i];
			num[i] = prd[i][NW] ? NW'(-prd[i]) : prd[i][NW-1:0];
			den[i] = dd[i/2][CB] ? DW'(-dd[i/2]) : DW'(dd[i/2]);
			neg[i] = prd[i][NW] ^ dd[i/2][CB];
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_div
		tps_div #(.NW(NW), .DW(DW), .QW(QW)) u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (state_q == ST_MUL),
			.num    (num[g]),
			.den    (den[g]),
			.neg    (neg[g]),
			.done   (done[g]),
			.quo    (quo[g])
		);
	end

	// crossing vertices lie on x = 0
	always_comb begin
		logic signed [QW:0] s [4];
		s[0] = $signed({{(QW+1-CB){e1x.y[CB-1]}}, e1x.y}) + quo[0];
		s[1] = $signed({{(QW+1-CB){e1x.z[CB-1]}}, e1x.z}) + quo[1];
		s[2] = $signed({{(QW+1-CB){e2x.y[CB-1]}}, e2x.y}) + quo[2];
		s[3] = $signed({{(QW+1-CB){e2x.z[CB-1]}}, e2x.z}) + quo[3];
		v1 = '{x: '0, y: s[0][CB-1:0], z: s[1][CB-1:0]};
		v2 = '{x: '0, y: s[2][CB-1:0], z: s[3][CB-1:0]};
	end

	// vertex order and side of each result triangle
	always_comb begin
		sel0 = SEL_A; sel1 = SEL_B; sel2 = SEL_C;
		side = (idx_q == 2'd2) ? !ent_q.flip : ent_q.flip;
		case (ent_q.kind)
			tps_pkg::KIND_PQ, tps_pkg::KIND_QS: begin
				case (idx_q)
					2'd0: begin
						sel0 = SEL_A; sel1 = SEL_X1;
						sel2 = (ent_q.kind == tps_pkg::KIND_PQ) ? SEL_C : SEL_B;
					end
					2'd1: begin
						sel0 = SEL_X1; sel1 = SEL_X2;
						sel2 = (ent_q.kind == tps_pkg::KIND_PQ) ? SEL_C : SEL_B;
					end
					default: begin
						sel0 = SEL_X1; sel1 = SEL_X2;
						sel2 = (ent_q.kind == tps_pkg::KIND_PQ) ? SEL_B : SEL_C;
					end
				endcase
			end
			tps_pkg::KIND_PS: begin
				case (idx_q)
					2'd0: begin
						sel0 = SEL_B; sel1 = SEL_X1;
						sel2 = ent_q.flip ? SEL_X2 : SEL_C;
					end
					2'd1: begin
						sel0 = ent_q.flip ? SEL_B : SEL_X1;
						sel1 = ent_q.flip ? SEL_C : SEL_X2;
						sel2 = ent_q.flip ? SEL_X2 : SEL_C;
					end
					default: begin
						sel0 = SEL_X2; sel1 = SEL_X1; sel2 = SEL_A;
					end
				endcase
			end
			default: begin
				side = (ent_q.kind == tps_pkg::KIND_RIGHT);
			end
		endcase
	end

	function automatic tps_pkg::vtx_t pick(sel_t s, tps_pkg::entry_t e,
			tps_pkg::vtx_t x1, tps_pkg::vtx_t x2);
		case (s)
			SEL_A:   pick = e.a;
			SEL_B:   pick = e.b;
			SEL_C:   pick = e.c;
			SEL_X1:  pick = x1;
			SEL_X2:  pick = x2;
			default: pick = e.a;
		endcase
	endfunction

	// x shift away from the plane with saturation
	function automatic tps_pkg::coord_t shift_x(tps_pkg::coord_t x, logic sd,
			logic [OB-1:0] off);
		logic signed [SW-1:0] sum;
		logic signed [SW-1:0] hi;
		logic signed [SW-1:0] lo;
		hi  = SW'((2 ** (CB - 1)) - 1);
		lo  = -hi - SW'(1);
		sum = sd ? SW'(x) + $signed(SW'(off)) : SW'(x) - $signed(SW'(off));
		if (sum > hi) begin
			shift_x = hi[CB-1:0];
		end else if (sum < lo) begin
			shift_x = lo[CB-1:0];
		end else begin
			shift_x = sum[CB-1:0];
		end
	endfunction

	assign w0   = pick(sel0, ent_q, v1, v2);
	assign w1   = pick(sel1, ent_q, v1, v2);
	assign w2   = pick(sel2, ent_q, v1, v2);
	assign load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign pop  = (state_q == ST_IDLE) && !empty;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						idx_q <= '0;
						if (head.kind == tps_pkg::KIND_LEFT ||
						    head.kind == tps_pkg::KIND_RIGHT) begin
							cnt_q   <= 2'd1;
							state_q <= ST_EMIT;
						end else begin
							cnt_q   <= 2'd3;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (done[0]) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == cnt_q - 1'b1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= head;
		end
		if (load) begin
			out_q.side     <= side;
			out_q.p0x      <= shift_x(w0.x, side, offset);
			out_q.p0y      <= w0.y;
			out_q.p0z      <= w0.z;
			out_q.p1x      <= shift_x(w1.x, side, offset);
			out_q.p1y      <= w1.y;
			out_q.p1z      <= w1.z;
			out_q.p2x      <= shift_x(w2.x, side, offset);
			out_q.p2y      <= w2.y;
			out_q.p2z      <= w2.z;
			out_q.last_tri <= (idx_q == cnt_q - 1'b1);
		end
	end

	// checks
	a_div_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) && done[0] |=> (state_q == ST_EMIT))
		else $error("divider finish did not start emission");
	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (idx_q < cnt_q))
		else $error("triangle index beyond count");
	a_last_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		load && (idx_q == cnt_q - 1'b1) |=> (state_q == ST_IDLE) && out_q.last_tri)
		else $error("final triangle not marked");

endmodule

// ----- rtl/triangle_plane_split_core.sv -----
// A one-sided triangle passes the front stage register, the queue, the entry register and
// the output register; a cut one goes from the entry register through the multiply state,
// COORD_BITS+1 divider steps and the divider done flag, then its 3 triangles are emitted.
// The back end takes a new triangle only after emitting all of the last one's triangles;
// cut triangles are paced by the bit-serial crossing dividers; the queue absorbs bursts.
// Reset: arst_n clears all control state and loads offset_q with one half.
// ----------------------------------------------------------------------------
// triangle_plane_split_core: split a triangle by the plane x = 0
// Classifier front, queue, and crossing/emission back end.
// ----------------------------------------------------------------------------
module triangle_plane_split_core #(
	parameter int QUEUE_DEPTH = tps_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [tps_pkg::OFFSET_BITS-1:0] cfg_wr_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  tps_pkg::in_t                    in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output tps_pkg::out_t                   out_data
);

	logic [tps_pkg::OFFSET_BITS-1:0] offset_q;
	logic                            push, full, pop, empty;
	tps_pkg::entry_t                 push_data, head;

	// offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= tps_pkg::OFFSET_RESET;
		end else if (cfg_wr_en) begin
			offset_q <= cfg_wr_data;
		end
	end

	tps_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	tps_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.head      (head)
	);

	tps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.offset    (offset_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ----- tb/sv/tb_triangle_plane_split_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_triangle_plane_split_core: self-checking bench for the plane split core
// Drives triangles through the valid/stall input, predicts the split triangles
// with a local model of the clipping rules and compares every output transaction.
// ----------------------------------------------------------------------------
module tb_triangle_plane_split_core;

	localparam int SIDE_LEFT  = 0;
	localparam int SIDE_RIGHT = 1;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_wr_en = 1'b0;
	logic [tps_pkg::OFFSET_BITS-1:0] cfg_wr_data = '0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	tps_pkg::in_t                    in_data = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	tps_pkg::out_t                   out_data;

	tps_pkg::out_t                   tri_expected[$];
	logic [tps_pkg::OFFSET_BITS-1:0] shift_amt = tps_pkg::OFFSET_RESET;
	int                              err_cnt = 0;
	bit                              idle_on = 1'b1;
	bit                              hold_req = 1'b0;

	triangle_plane_split_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

	always #5 clk = ~clk;

	// run limit
	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end

	// ---------------- predictor ----------------
	function automatic longint shifted_x(longint x, int sd);
		longint v;
		v = sd ? x + longint'(shift_amt) : x - longint'(shift_amt);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v;
	endfunction

	// append one expected transaction at the tail
	function automatic void append_tri(tps_pkg::out_t t);
		tri_expected = {tri_expected, t};
	endfunction

	function automatic void push_tri(int sd, longint v0[3], longint v1[3], longint v2[3]);
		tps_pkg::out_t t;
		t.side = sd[0];
		t.p0x = tps_pkg::coord_t'(shifted_x(v0[0], sd));
		t.p0y = tps_pkg::coord_t'(v0[1]); t.p0z = tps_pkg::coord_t'(v0[2]);
		t.p1x = tps_pkg::coord_t'(shifted_x(v1[0], sd));
		t.p1y = tps_pkg::coord_t'(v1[1]); t.p1z = tps_pkg::coord_t'(v1[2]);
		t.p2x = tps_pkg::coord_t'(shifted_x(v2[0], sd));
		t.p2y = tps_pkg::coord_t'(v2[1]); t.p2z = tps_pkg::coord_t'(v2[2]);
		t.last_tri = 1'b0;
		append_tri(t);
	endfunction

	// crossing of edge u-w with x = 0; y and z offsets from u truncated toward zero
	function automatic bit edge_cut(longint u[3], longint w[3], output longint p[3]);
		longint den;
		p = '{0, 0, 0};
		if (u[0] == w[0]) return 0;
		if (!((u[0] <= 0 && w[0] >= 0) || (u[0] >= 0 && w[0] <= 0))) return 0;
		den = u[0] - w[0];
		p[1] = u[1] + (u[0] * (w[1] - u[1])) / den;
		p[2] = u[2] + (u[0] * (w[2] - u[2])) / den;
		return 1;
	endfunction

	function automatic void predict_split(tps_pkg::in_t d);
		longint a[3], b[3], c[3], p[3], q[3], s[3];
		bit hp, hq, hs;
		int n0, lo, hi;
		tps_pkg::out_t t;
		a = '{d.ax, d.ay, d.az};
		b = '{d.bx, d.by_coord, d.bz};
		c = '{d.cx, d.cy, d.cz};
		n0 = tri_expected.size();
		lo = SIDE_LEFT;
		hi = SIDE_RIGHT;
		if (a[0] <= 0 && b[0] <= 0 && c[0] <= 0) push_tri(SIDE_LEFT, a, b, c);
		else if (a[0] >= 0 && b[0] >= 0 && c[0] >= 0) push_tri(SIDE_RIGHT, a, b, c);
		else begin
			hp = edge_cut(a, b, p);
			hq = edge_cut(b, c, q);
			hs = edge_cut(c, a, s);
			if (hp && hq) begin
				if (a[0] > 0) begin lo = SIDE_RIGHT; hi = SIDE_LEFT; end
				push_tri(lo, a, p, c); push_tri(lo, p, q, c); push_tri(hi, p, q, b);
			end else if (hq && hs) begin
				if (a[0] > 0) begin lo = SIDE_RIGHT; hi = SIDE_LEFT; end
				push_tri(lo, a, s, b); push_tri(lo, s, q, b); push_tri(hi, s, q, c);
			end else if (hp && hs) begin
				if (b[0] <= 0) begin
					push_tri(SIDE_LEFT, b, p, c); push_tri(SIDE_LEFT, p, s, c);
					push_tri(SIDE_RIGHT, s, p, a);
				end else begin
					push_tri(SIDE_RIGHT, b, p, s); push_tri(SIDE_RIGHT, b, c, s);
					push_tri(SIDE_LEFT, s, p, a);
				end
			end
		end
		if (tri_expected.size() > n0) begin
			t = tri_expected.pop_back();
			t.last_tri = 1'b1;
			append_tri(t);
		end
	endfunction

	// ---------------- result checker ----------------
	always @(posedge clk) begin
		tps_pkg::out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (tri_expected.size() == 0) begin
				$error("unexpected output transaction %h", out_data);
				err_cnt++;
			end else begin
				e = tri_expected.pop_front();
				if (out_data.side !== e.side) begin
					$error("side exp %0d got %0d", e.side, out_data.side); err_cnt++;
				end
				if (out_data.p0x !== e.p0x) begin
					$error("p0x exp %0d got %0d", e.p0x, out_data.p0x); err_cnt++;
				end
				if (out_data.p0y !== e.p0y) begin
					$error("p0y exp %0d got %0d", e.p0y, out_data.p0y); err_cnt++;
				end
				if (out_data.p0z !== e.p0z) begin
					$error("p0z exp %0d got %0d", e.p0z, out_data.p0z); err_cnt++;
				end
				if (out_data.p1x !== e.p1x) begin
					$error("p1x exp %0d got %0d", e.p1x, out_data.p1x); err_cnt++;
				end
				if (out_data.p1y !== e.p1y) begin
					$error("p1y exp %0d got %0d", e.p1y, out_data.p1y); err_cnt++;
				end
				if (out_data.p1z !== e.p1z) begin
					$error("p1z exp %0d got %0d", e.p1z, out_data.p1z); err_cnt++;
				end
				if (out_data.p2x !== e.p2x) begin
					$error("p2x exp %0d got %0d", e.p2x, out_data.p2x); err_cnt++;
				end
				if (out_data.p2y !== e.p2y) begin
					$error("p2y exp %0d got %0d", e.p2y, out_data.p2y); err_cnt++;
				end
				if (out_data.p2z !== e.p2z) begin
					$error("p2z exp %0d got %0d", e.p2z, out_data.p2z); err_cnt++;
				end
				if (out_data.last_tri !== e.last_tri) begin
					$error("last_tri exp %0d got %0d", e.last_tri, out_data.last_tri);
					err_cnt++;
				end
			end
		end
	end

	// ---------------- receiver stall ----------------
	always @(posedge clk) begin
		int hold_cnt;
		if (hold_req) begin
			hold_req <= 1'b0;
			hold_cnt = 300;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else
			out_stall <= idle_on && ($urandom_range(99) < 22);
	end

	// ---------------- stimulus helpers ----------------
	// valid stays up between back-to-back transactions
	task automatic send_tri(tps_pkg::in_t d);
		while (idle_on && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= d;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_split(d);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (tri_expected.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_offset(logic [tps_pkg::OFFSET_BITS-1:0] v);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		shift_amt = v;
	endtask

	function automatic tps_pkg::in_t mk_tri(int x0, int y0, int z0, int x1, int y1, int z1,
		int x2, int y2, int z2);
		tps_pkg::in_t d;
		d.ax = tps_pkg::coord_t'(x0); d.ay = tps_pkg::coord_t'(y0);
		d.az = tps_pkg::coord_t'(z0);
		d.bx = tps_pkg::coord_t'(x1); d.by_coord = tps_pkg::coord_t'(y1);
		d.bz = tps_pkg::coord_t'(z1);
		d.cx = tps_pkg::coord_t'(x2); d.cy = tps_pkg::coord_t'(y2);
		d.cz = tps_pkg::coord_t'(z2);
		return d;
	endfunction

	function automatic int rnd_coord(bit full);
		if (full) return int'($urandom_range(65535)) - 32768;
		return int'($urandom_range(32768)) - 16384;
	endfunction

	function automatic tps_pkg::in_t rnd_tri();
		tps_pkg::in_t d;
		int m;
		bit full;
		m = $urandom_range(9);
		full = ($urandom_range(9) == 0);
		d = mk_tri(rnd_coord(full), rnd_coord(full), rnd_coord(full), rnd_coord(full),
			rnd_coord(full), rnd_coord(full), rnd_coord(full), rnd_coord(full),
			rnd_coord(full));
		// random, forced one-sided on either side, or with one x set to zero
		if (m < 2) begin
			d.ax = tps_pkg::coord_t'(-int'($urandom_range(16384)));
			d.bx = tps_pkg::coord_t'(-int'($urandom_range(16384)));
			d.cx = tps_pkg::coord_t'(-int'($urandom_range(16384)));
		end else if (m < 4) begin
			d.ax = tps_pkg::coord_t'($urandom_range(16384));
			d.bx = tps_pkg::coord_t'($urandom_range(16384));
			d.cx = tps_pkg::coord_t'($urandom_range(16384));
		end else if (m == 4) begin
			case ($urandom_range(2))
				0: d.ax = '0;
				1: d.bx = '0;
				default: d.cx = '0;
			endcase
		end
		return d;
	endfunction

	// ---------------- tests ----------------
	task automatic test_directed();
		send_tri(mk_tri(-100, 5, 6, -200, 7, 8, -300, 9, 10));
		send_tri(mk_tri(100, 5, 6, 200, 7, 8, 300, 9, 10));
		send_tri(mk_tri(0, 1, 2, 0, 3, 4, 0, 5, 6));
		send_tri(mk_tri(0, 1, 2, 0, 3, 4, 100, 5, 6));
		send_tri(mk_tri(-16384, -16384, -16384, 16384, 16384, 16384, 16384, -16384, 16384));
		send_tri(mk_tri(16384, 16384, -16384, -16384, -16384, 16384, -16384, 0, 0));
		send_tri(mk_tri(-1000, 0, 0, 3000, 400, -400, -500, 999, 7));
		send_tri(mk_tri(1000, 0, 0, -3000, 400, -400, 500, 999, 7));
		send_tri(mk_tri(-1000, 10, 20, -2000, 30, 40, 3000, -50, 60));
		send_tri(mk_tri(1000, 10, 20, 2000, 30, 40, -3000, -50, 60));
		send_tri(mk_tri(0, 10, 20, 2000, 30, 40, -3000, -50, 60));
		send_tri(mk_tri(-16384, 16384, 16384, 16384, -16384, -16384, 0, 1, 1));
		send_tri(mk_tri(-32768, 32767, -32768, 32767, -32768, 32767, 1, 0, 0));
		send_tri(mk_tri(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
		send_tri(mk_tri(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
			-32768));
		send_tri(mk_tri(-1, 3, -3, 1, -3, 3, -1, 7, -7));
	endtask

	task automatic test_offsets();
		set_offset('0);
		repeat (6) send_tri(rnd_tri());
		set_offset(14'h3fff);
		repeat (6) send_tri(rnd_tri());
		send_tri(mk_tri(32767, 1, 1, 32000, 2, 2, 30000, 3, 3));
		send_tri(mk_tri(-32768, 1, 1, -32000, 2, 2, -30000, 3, 3));
		set_offset(14'd8192);
	endtask

	task automatic test_backpressure();
		hold_req <= 1'b1;
		repeat (20) send_tri(rnd_tri());
	endtask

	task automatic test_random();
		int i;
		for (i = 0; i < 180; i++) begin
			idle_on = !(i >= 80 && i < 130);
			if (i == 115) set_offset(tps_pkg::OFFSET_BITS'($urandom_range(8192)));
			send_tri(rnd_tri());
		end
		idle_on = 1'b1;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_offsets();
		test_backpressure();
		test_random();
		drain();
		if (err_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
